// ----- hw/rtl/fss_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the fuzzy subsequence scorer.
// No dependencies; used by fss_emit, fuzzy_subsequence_scorer_unit and the testbench.
package fss_pkg;

    localparam int unsigned QUERY_SLOTS = 16;
    localparam int unsigned QIDX_W      = 5;
    localparam int unsigned POS_W       = 8;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned SCORE_W     = 8;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned TOTAL_W     = 9;
    localparam int unsigned OUT_DATA_W  = 32;

    localparam logic [1:0] CFG_QUERY_LOW  = 2'd0;
    localparam logic [1:0] CFG_QUERY_HIGH = 2'd1;
    localparam logic [1:0] CFG_QUERY_LEN  = 2'd2;

    localparam logic [7:0] CHAR_NUL        = 8'h00;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_DASH       = 8'h2D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_SLASH      = 8'h2F;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;

    // half-point increments
    localparam logic [TOTAL_W-1:0] PTS_BASE     = 9'd2;
    localparam logic [TOTAL_W-1:0] PTS_BOUNDARY = 9'd16;
    localparam logic [TOTAL_W-1:0] PTS_RUN      = 9'd10;
    localparam logic [TOTAL_W-1:0] PTS_LOWER    = 9'd1;

    localparam logic [SCORE_W-1:0] SCORE_EMPTY = 8'd1;

    typedef enum logic
    {
        KIND_POSITION = 1'b0,
        KIND_VERDICT  = 1'b1
    } kind_t;

    // end-of-label summary handed to the emitter
    typedef struct packed
    {
        logic               load;
        logic               matched;
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] entries;
    } verdict_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_DASH) || (c == CHAR_UNDERSCORE)
            || (c == CHAR_SLASH) || (c == CHAR_DOT);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

endpackage

// ----- hw/rtl/fuzzy_subsequence_scorer_unit.sv -----
`timescale 1ns / 1ps
// Fuzzy subsequence scorer, top level: input register, match and score
// logic, label state. Depends on fss_pkg and fss_emit.
//
// Usage:
//   s_* channel carries one label byte per transaction; a zero byte ends
//   the label. m_* channel carries results: tuser gives the kind (position
//   entry or verdict), tlast marks the verdict closing each label.
//   Query characters and length are set via cfg_we/cfg_index/cfg_data,
//   by the user only while idle; the block itself does not enforce this.
// Throughput: one label byte per cycle while no terminator is held. A
//   matching label yields query-length plus one results, else one verdict;
//   they leave the output register one per cycle while m_tready is high.
// Result path: a taken terminator loads the emitter's snapshot and busy
//   flag; the label's first result then goes into the output register.
// Stalls: label bytes keep flowing while results drain; the next
//   terminator waits in the input register until the emitter has loaded
//   the previous label's verdict into the output register. A stalled
//   receiver holds the output register and, in turn, that terminator.
// Reset: clears label state, query registers and both valid flags.
module fuzzy_subsequence_scorer_unit #(
    parameter int unsigned QUERY_MAX = 16,
    parameter int unsigned LABEL_MAX = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [63:0]                        cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // label_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fss_pkg::OUT_DATA_W-1:0]     m_tdata,   // query_slot, position, matched,
                                                          // score, hit_count, zero pad
    output logic                               m_tuser,   // kind
    output logic                               m_tlast    // last_of_run
);
    import fss_pkg::*;

    localparam int unsigned QIW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
    localparam int unsigned LW  = $clog2(LABEL_MAX);
    localparam logic [LW-1:0]      LABEL_LAST = LW'(LABEL_MAX - 1);
    localparam logic [QIDX_W-1:0]  QLEN_CAP   = QIDX_W'(QUERY_MAX);

    logic [63:0]        qlow_reg;
    logic [63:0]        qhigh_reg;
    logic [QIDX_W-1:0]  qlen_reg;

    logic               byte_v_reg;
    logic [7:0]         byte_reg;

    logic [QIDX_W-1:0]  qidx_reg,   qidx_next;
    logic [LW-1:0]      lidx_reg,   lidx_next;
    logic [7:0]         prev_reg,   prev_next;
    logic               pmatch_reg, pmatch_next;
    logic [TOTAL_W-1:0] total_reg,  total_next;
    logic [QUERY_MAX-1:0][7:0] pos_reg;

    logic [15:0][7:0]   qchars;
    logic [QIDX_W-1:0]  qlen;
    logic               busy;
    logic               take;
    logic               proc;
    logic               term;
    logic               hit;
    logic               active;
    logic               char_hit;
    logic [TOTAL_W-1:0] pts;
    verdict_t           verdict;

    assign qchars = {qhigh_reg, qlow_reg};
    assign qlen   = (qlen_reg > QLEN_CAP) ? QLEN_CAP : qlen_reg;

    assign term     = byte_reg == CHAR_NUL;
    assign take     = !(term && busy);
    assign proc     = byte_v_reg && take;
    assign s_tready = !byte_v_reg || take;

    assign active   = qidx_reg < qlen;
    assign char_hit = active && (fold_case(byte_reg) == fold_case(qchars[qidx_reg[3:0]]));
    assign hit      = (qlen != '0) && (qidx_reg >= qlen);

    always_comb
    begin
        pts = PTS_BASE;
        if (lidx_reg == '0 || is_separator(prev_reg))
        begin
            pts = pts + PTS_BOUNDARY;
        end
        if (pmatch_reg && lidx_reg != '0)
        begin
            pts = pts + PTS_RUN;
        end
        if (is_lower(byte_reg))
        begin
            pts = pts + PTS_LOWER;
        end
    end

    always_comb
    begin
        qidx_next   = qidx_reg;
        lidx_next   = lidx_reg;
        prev_next   = prev_reg;
        pmatch_next = pmatch_reg;
        total_next  = total_reg;
        if (proc)
        begin
            if (term)
            begin
                qidx_next   = '0;
                lidx_next   = '0;
                prev_next   = '0;
                pmatch_next = 1'b0;
                total_next  = '0;
            end
            else
            begin
                if (active)
                begin
                    pmatch_next = char_hit;
                    if (char_hit)
                    begin
                        total_next = total_reg + pts;
                        qidx_next  = qidx_reg + 1'b1;
                    end
                end
                prev_next = byte_reg;
                if (lidx_reg < LABEL_LAST)
                begin
                    lidx_next = lidx_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        verdict.load    = proc && term;
        verdict.matched = (qlen == '0) || hit;
        verdict.score   = (qlen == '0) ? SCORE_EMPTY
                        : (hit ? total_reg[TOTAL_W-1:1] : '0);
        verdict.count   = hit ? qlen : '0;
        verdict.entries = hit ? qlen : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlow_reg   <= '0;
            qhigh_reg  <= '0;
            qlen_reg   <= '0;
            byte_v_reg <= 1'b0;
            qidx_reg   <= '0;
            lidx_reg   <= '0;
            prev_reg   <= '0;
            pmatch_reg <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUERY_LOW:  qlow_reg  <= cfg_data;
                    CFG_QUERY_HIGH: qhigh_reg <= cfg_data;
                    CFG_QUERY_LEN:  qlen_reg  <= cfg_data[QIDX_W-1:0];
                    default:        ;
                endcase
            end
            if (s_tready)
            begin
                byte_v_reg <= s_tvalid;
            end
            qidx_reg   <= qidx_next;
            lidx_reg   <= lidx_next;
            prev_reg   <= prev_next;
            pmatch_reg <= pmatch_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
        if (proc && !term && char_hit)
        begin
            pos_reg[qidx_reg[QIW-1:0]] <= 8'(lidx_reg);
        end
    end

    fss_emit #(
        .QUERY_MAX (QUERY_MAX)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .verdict   (verdict),
        .positions (pos_reg),
        .busy      (busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef ASSERT_OFF
    a_qidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qidx_reg <= QLEN_CAP)
        else $error("query index beyond query capacity");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (byte_v_reg && term && busy))
        else $error("input stalled without a waiting terminator");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && term) |=> (qidx_reg == '0 && lidx_reg == '0 && total_reg == '0))
        else $error("label state not cleared after terminator");
`endif

endmodule

// ----- hw/rtl/fss_emit.sv -----
`timescale 1ns / 1ps
// Result emitter: snapshots the match positions of a finished label and
// streams position entries then the verdict. Depends on fss_pkg.
module fss_emit #(
    parameter int unsigned QUERY_MAX = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fss_pkg::verdict_t                   verdict,
    input  logic [QUERY_MAX-1:0][7:0]           positions,
    output logic                                busy,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fss_pkg::OUT_DATA_W-1:0]      m_tdata,   // slot, position, matched, score, count
    output logic                                m_tuser,   // kind
    output logic                                m_tlast    // last_of_run
);
    import fss_pkg::*;

    localparam int unsigned QIW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

    logic [QUERY_MAX-1:0][7:0] snap_reg;
    logic                      busy_reg;
    logic [COUNT_W-1:0]        cnt_reg;
    logic [COUNT_W-1:0]        entries_reg;
    logic                      matched_reg;
    logic [SCORE_W-1:0]        score_reg;
    logic [COUNT_W-1:0]        count_reg;

    logic                      out_valid_reg;
    kind_t                     out_kind_reg;
    logic [SLOT_W-1:0]         out_slot_reg;
    logic [POS_W-1:0]          out_pos_reg;
    logic                      out_matched_reg;
    logic [SCORE_W-1:0]        out_score_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic                      out_last_reg;

    logic                      advance;
    logic                      emit_entry;

    assign advance    = !out_valid_reg || m_tready;
    assign emit_entry = cnt_reg < entries_reg;

    always_ff @(posedge clk)
    begin
        if (verdict.load)
        begin
            snap_reg    <= positions;
            entries_reg <= verdict.entries;
            matched_reg <= verdict.matched;
            score_reg   <= verdict.score;
            count_reg   <= verdict.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (verdict.load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (advance && busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!emit_entry)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (advance)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && busy_reg)
        begin
            if (emit_entry)
            begin
                out_kind_reg    <= KIND_POSITION;
                out_slot_reg    <= SLOT_W'(cnt_reg);
                out_pos_reg     <= snap_reg[cnt_reg[QIW-1:0]];
                out_matched_reg <= 1'b0;
                out_score_reg   <= '0;
                out_count_reg   <= '0;
                out_last_reg    <= 1'b0;
            end
            else
            begin
                out_kind_reg    <= KIND_VERDICT;
                out_slot_reg    <= '0;
                out_pos_reg     <= '0;
                out_matched_reg <= matched_reg;
                out_score_reg   <= score_reg;
                out_count_reg   <= count_reg;
                out_last_reg    <= 1'b1;
            end
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_count_reg, out_score_reg, out_matched_reg,
                       out_pos_reg, out_slot_reg};

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.load |-> !busy_reg)
        else $error("label summary loaded while emitter busy");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= entries_reg))
        else $error("emitter count ran past entry count");

    a_verdict_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && busy_reg && !emit_entry) |=> !busy_reg)
        else $error("emitter stayed busy after verdict");

    a_last_on_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_kind_reg == KIND_VERDICT)))
        else $error("last flag does not mark the verdict");
`endif

endmodule

// ----- verif/tb_fuzzy_subsequence_scorer_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fuzzy_subsequence_scorer_unit: directed and random label
// streams, scored by a cycle-free predictor and compared result by result.
// Depends on fss_pkg and the scorer RTL only.
module tb_fuzzy_subsequence_scorer_unit;

    import fss_pkg::*;

    localparam logic [1:0] CFG_SPARE      = 2'd3;
    localparam int         LABEL_LAST     = 255;
    localparam int         IDLE_HEAVY     = 81;
    localparam int         IDLE_BOTH      = 22;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         REPORT_LIMIT   = 10;
    localparam int         TIMEOUT_CYCLES = 400000;

    typedef enum int
    {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct
    {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [POS_W-1:0]   pos;
        logic               matched;
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
        logic               last;
    } fss_result_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = CFG_QUERY_LOW;
    logic [63:0]           cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = CHAR_NUL;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    pace_t pace = PACE_FREE;
    int    mismatches = 0;
    int    cycle_count = 0;

    // predictor copy of the query registers and the per-label state
    logic [127:0]       query_chars = '0;
    logic [4:0]         query_len   = '0;
    int                 q_idx       = 0;
    int                 lbl_idx     = 0;
    logic [7:0]         prev_byte   = CHAR_NUL;
    bit                 prev_hit    = 1'b0;
    logic [TOTAL_W-1:0] half_total  = '0;
    logic [POS_W-1:0]   match_pos [QUERY_SLOTS];

    fss_result_t awaited_results [$];

    fuzzy_subsequence_scorer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("tb_fuzzy_subsequence_scorer_unit: FAIL");
            $finish;
        end
    end

    function automatic bit sender_gap();
        if (pace == PACE_SEND_IDLE)
        begin
            return $urandom_range(99) < IDLE_HEAVY;
        end
        if (pace == PACE_BOTH)
        begin
            return $urandom_range(99) < IDLE_BOTH;
        end
        return 1'b0;
    endfunction

    function automatic bit receiver_stall();
        if (pace == PACE_RECV_STALL)
        begin
            return $urandom_range(99) < IDLE_HEAVY;
        end
        if (pace == PACE_BOTH)
        begin
            return $urandom_range(99) < IDLE_BOTH;
        end
        return 1'b0;
    endfunction

    always @(negedge clk)
    begin
        m_tready <= !receiver_stall();
    end

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit word_break(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_DASH || c == CHAR_UNDERSCORE
            || c == CHAR_SLASH || c == CHAR_DOT;
    endfunction

    function automatic int active_len();
        return (query_len > QUERY_SLOTS) ? QUERY_SLOTS : int'(query_len);
    endfunction

    function automatic fss_result_t make_result(input logic kind, input int slot,
                                                input logic [7:0] pos, input logic matched,
                                                input logic [7:0] score, input int count);
        fss_result_t r;
        r.kind    = kind;
        r.slot    = slot[SLOT_W-1:0];
        r.pos     = pos;
        r.matched = matched;
        r.score   = score;
        r.count   = count[COUNT_W-1:0];
        r.last    = kind;
        return r;
    endfunction

    // advance the per-label state by one accepted byte and queue its results
    task automatic score_byte(input logic [7:0] b);
        int                 qlen;
        logic [TOTAL_W-1:0] pts;
        qlen = active_len();
        if (b == CHAR_NUL)
        begin
            if (qlen == 0)
            begin
                awaited_results.push_back(make_result(KIND_VERDICT, 0, '0, 1'b1, SCORE_EMPTY, 0));
            end
            else if (q_idx >= qlen)
            begin
                for (int j = 0; j < qlen; j++)
                begin
                    awaited_results.push_back(make_result(KIND_POSITION, j, match_pos[j],
                                                          1'b0, '0, 0));
                end
                awaited_results.push_back(make_result(KIND_VERDICT, 0, '0, 1'b1,
                                                      half_total[TOTAL_W-1:1], qlen));
            end
            else
            begin
                awaited_results.push_back(make_result(KIND_VERDICT, 0, '0, 1'b0, '0, 0));
            end
            q_idx      = 0;
            lbl_idx    = 0;
            prev_byte  = CHAR_NUL;
            prev_hit   = 1'b0;
            half_total = '0;
        end
        else
        begin
            if (q_idx < qlen)
            begin
                if (lower_of(b) == lower_of(query_chars[q_idx*8 +: 8]))
                begin
                    pts = 9'd2;
                    if (lbl_idx == 0 || word_break(prev_byte))
                    begin
                        pts = pts + 9'd16;
                    end
                    if (prev_hit && lbl_idx > 0)
                    begin
                        pts = pts + 9'd10;
                    end
                    if (b >= "a" && b <= "z")
                    begin
                        pts = pts + 9'd1;
                    end
                    half_total       = half_total + pts;
                    match_pos[q_idx] = lbl_idx[7:0];
                    q_idx++;
                    prev_hit = 1'b1;
                end
                else
                begin
                    prev_hit = 1'b0;
                end
            end
            prev_byte = b;
            if (lbl_idx < LABEL_LAST)
            begin
                lbl_idx++;
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            flag_mismatch(what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        fss_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                flag_mismatch("result with nothing awaited", '0, m_tdata);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("query_slot", want.slot, m_tdata[3:0]);
                check_field("position", want.pos, m_tdata[11:4]);
                check_field("matched", want.matched, m_tdata[12]);
                check_field("score", want.score, m_tdata[20:13]);
                check_field("hit_count", want.count, m_tdata[25:21]);
                check_field("last_of_run", want.last, m_tlast);
            end
        end
    end

    // enter at a falling edge, leave at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] b);
        while (sender_gap())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        score_byte(b);
        @(negedge clk);
    endtask

    task automatic send_label(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
        send_byte(CHAR_NUL);
    endtask

    // hold the sender until every awaited result has left, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        case (idx)
            CFG_QUERY_LOW:  query_chars[63:0]   = val;
            CFG_QUERY_HIGH: query_chars[127:64] = val;
            CFG_QUERY_LEN:  query_len           = val[4:0];
            default:        ;
        endcase
    endtask

    task automatic set_query(input logic [127:0] chars, input logic [4:0] len);
        logic [63:0] len_word;
        len_word      = {$urandom, $urandom};
        len_word[4:0] = len;
        settle();
        write_reg(CFG_QUERY_LOW, chars[63:0]);
        write_reg(CFG_QUERY_HIGH, chars[127:64]);
        write_reg(CFG_QUERY_LEN, len_word);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [127:0] pack_query(input string s);
        logic [127:0] q;
        q = '0;
        for (int i = 0; i < s.len() && i < QUERY_SLOTS; i++)
        begin
            q[i*8 +: 8] = s[i];
        end
        return q;
    endfunction

    function automatic logic [7:0] label_char();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'("a" + $urandom_range(25));
            4, 5:       return 8'("A" + $urandom_range(25));
            6:
            begin
                case ($urandom_range(4))
                    0:       return CHAR_SPACE;
                    1:       return CHAR_DASH;
                    2:       return CHAR_UNDERSCORE;
                    3:       return CHAR_SLASH;
                    default: return CHAR_DOT;
                endcase
            end
            7:       return 8'("0" + $urandom_range(9));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic test_empty_query();
        pace = PACE_FREE;
        send_label("");
        send_label("Ab-c");
        settle();
        write_reg(CFG_SPARE, '1);
        cfg_we <= 1'b0;
        send_label("x");
    endtask

    task automatic test_scoring();
        pace = PACE_BOTH;
        set_query(pack_query("ab-C"), 5'd4);
        send_label("ab-c");
        send_label("AB-c");
        send_label("xa b-zc");
        send_label("a_b.-/C");
        send_label("abc");
        send_label("zzab-cab-c");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_label("ab-c");
    endtask

    task automatic test_full_query();
        pace = PACE_BOTH;
        set_query(pack_query("a-a-a-a-a-a-a-a-"), 5'd16);
        send_label("a-a-a-a-a-a-a-a-");
        send_label(" A--A--a--a--a--a--a--a--");
        set_query('1, 5'd31);
        for (int i = 0; i < QUERY_SLOTS; i++)
        begin
            send_byte(8'hFF);
        end
        send_byte(CHAR_NUL);
    endtask

    task automatic test_zero_query_char();
        logic [127:0] q;
        pace = PACE_FREE;
        q        = pack_query("a?b");
        q[15:8]  = CHAR_NUL;
        set_query(q, 5'd3);
        send_label("ab");
        send_label("a?b");
        set_query(q, 5'd1);
        send_label("xA");
    endtask

    task automatic test_mid_label_change();
        pace = PACE_BOTH;
        set_query(pack_query("abc"), 5'd3);
        send_byte("a");
        send_byte("b");
        set_query(pack_query("abc"), 5'd1);
        send_byte("c");
        send_byte(CHAR_NUL);
        set_query(pack_query("ab"), 5'd2);
        send_byte("x");
        send_byte("a");
        set_query(pack_query("aq"), 5'd2);
        send_label("Q");
    endtask

    task automatic test_long_label();
        pace = PACE_FREE;
        set_query(pack_query("zq"), 5'd2);
        repeat (256) send_byte("a");
        send_label("zQ");
        send_label("zq");
    endtask

    task automatic random_query();
        logic [127:0] q;
        logic [4:0]   len;
        int           r;
        r = $urandom_range(15);
        if (r == 0)
        begin
            len = 5'd0;
        end
        else if (r == 1)
        begin
            len = 5'd16;
        end
        else if (r == 2)
        begin
            len = 5'($urandom_range(17, 31));
        end
        else
        begin
            len = 5'($urandom_range(1, 8));
        end
        if ($urandom_range(3) == 0)
        begin
            q = {$urandom, $urandom, $urandom, $urandom};
        end
        else
        begin
            for (int i = 0; i < QUERY_SLOTS; i++)
            begin
                q[i*8 +: 8] = ($urandom_range(23) == 0) ? CHAR_NUL : label_char();
            end
        end
        set_query(q, len);
    endtask

    // mostly labels that carry the query in order, with filler, case flips and the odd
    // dropped byte; the rest is noise
    task automatic send_random_label(output int count);
        logic [7:0] lbl [$];
        logic [7:0] c;
        int         fill;
        if ($urandom_range(9) < 7)
        begin
            for (int j = 0; j < active_len(); j++)
            begin
                fill = $urandom_range(1) ? 0 : $urandom_range(1, 3);
                repeat (fill) lbl.push_back(label_char());
                c = query_chars[j*8 +: 8];
                if (c == CHAR_NUL)
                begin
                    c = label_char();
                end
                else if (is_alpha(c) && $urandom_range(1))
                begin
                    c = c ^ 8'h20;
                end
                lbl.push_back(c);
            end
            if ($urandom_range(7) == 0 && lbl.size() > 0)
            begin
                lbl.delete($urandom_range(lbl.size() - 1));
            end
            repeat ($urandom_range(3)) lbl.push_back(label_char());
        end
        else
        begin
            repeat ($urandom_range(20)) lbl.push_back(label_char());
        end
        foreach (lbl[i])
        begin
            send_byte(lbl[i]);
        end
        send_byte(CHAR_NUL);
        count = lbl.size() + 1;
    endtask

    task automatic test_random(input pace_t p, input int budget);
        int sent;
        int goal;
        int n;
        pace = p;
        sent = 0;
        while (sent < budget)
        begin
            random_query();
            goal = sent + budget / 3;
            while (sent < goal)
            begin
                send_random_label(n);
                sent += n;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_query();
        test_scoring();
        test_full_query();
        test_zero_query_char();
        test_mid_label_change();
        test_long_label();
        test_random(PACE_FREE, 16);
        test_random(PACE_SEND_IDLE, 16);
        test_random(PACE_RECV_STALL, 16);
        test_random(PACE_BOTH, 16);
        settle();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("tb_fuzzy_subsequence_scorer_unit: PASS");
        end
        else
        begin
            $display("tb_fuzzy_subsequence_scorer_unit: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/fss_pkg.sv
hw/rtl/fss_emit.sv
hw/rtl/fuzzy_subsequence_scorer_unit.sv
verif/tb_fuzzy_subsequence_scorer_unit.sv
